@@ rtl/gsfa_pkg.sv @@
// Package for the grid splat flow accumulator.
// Holds the word types, operation and register codes, and the controller interface.
// Depends on nothing.
`timescale 1ns / 1ps

package gsfa_pkg;

  localparam int DEF_MAX_COLS = 256;
  localparam int DEF_MAX_ROWS = 256;
  localparam int DEF_HALO     = 1;

  localparam int MAP_DIM_W = 9;
  localparam int CFG_IDX_W = 2;
  localparam logic [MAP_DIM_W-1:0] MAP_DIM_RESET = 9'd256;
  localparam logic [16:0] FLOW_STEP = 17'd64;

  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_STAMP = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;
  localparam logic [1:0] OP_CHECK = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_MAP_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAP_HEIGHT = 2'd1;

  typedef struct packed {
    logic [1:0]        operation;
    logic [7:0]        tile_x;
    logic [7:0]        tile_y;
    logic signed [7:0] vec_x;
    logic signed [7:0] vec_y;
    logic              ground_unit;
    logic              friendly;
  } gsfa_in_t;

  typedef struct packed {
    logic signed [15:0] tile_flow_x;
    logic signed [15:0] tile_flow_y;
    logic [15:0]        tile_mass;
    logic [31:0]        grid_hash;
  } gsfa_out_t;

  typedef enum logic [1:0] {
    MUL_X,
    MUL_Y,
    MUL_M
  } gsfa_mul_sel_t;

  typedef struct packed {
    logic          latch;
    logic          clr_wr;
    logic          st_rd;
    logic          st_wr;
    logic          st_step;
    logic          rd_rd;
    logic          rd_cap;
    logic          ck_rd;
    logic          mul;
    gsfa_mul_sel_t mul_sel;
    logic          acc;
    logic          wk_step;
    logic          wk_rst;
    logic          load_out;
  } gsfa_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic st_inmap;
    logic st_last;
    logic rd_inmap;
    logic wk_last;
  } gsfa_status_t;

endpackage

@@ rtl/gsfa_ram.sv @@
// Generic single-port RAM with a registered read.
// Depends on nothing.
`timescale 1ns / 1ps

module gsfa_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

@@ rtl/gsfa_datapath.sv @@
// Datapath: map registers, tile counters, the grid RAM, saturating update and hash.
// Depends on gsfa_pkg and gsfa_ram.
`timescale 1ns / 1ps

module gsfa_datapath
  import gsfa_pkg::*;
#(
  parameter int MAX_COLS = DEF_MAX_COLS,
  parameter int MAX_ROWS = DEF_MAX_ROWS,
  parameter int HALO     = DEF_HALO
) (
  input  logic                 clk,
  input  logic                 rst,
  input  gsfa_in_t             item,
  input  logic                 cfg_valid,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [MAP_DIM_W-1:0] cfg_data,
  input  gsfa_cmd_t            cmd,
  output gsfa_status_t         status,
  output gsfa_out_t            result
);

  localparam int CELLS  = MAX_COLS * MAX_ROWS;
  localparam int ADDR_W = $clog2(CELLS);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(CELLS - 1);
  localparam logic [10:0] COLS_L = 11'(MAX_COLS);
  localparam logic [10:0] ROWS_L = 11'(MAX_ROWS);
  localparam logic signed [2:0] HLO     = 3'(HALO);
  localparam logic signed [2:0] NEG_HLO = -3'(HALO);

  logic [MAP_DIM_W-1:0] map_width, map_height;
  logic [10:0] eff_w, eff_h, mw_ext, mh_ext;
  logic [ADDR_W-1:0] clr_addr;
  logic signed [2:0] dx, dy;
  logic [9:0] wx, wy;
  logic [7:0] t_x, t_y;
  logic signed [7:0] v_x, v_y;
  logic [31:0] hash, factor, prod, factor_next;
  logic [15:0] res_fx, res_fy, res_m, mul_src;
  logic [10:0] sx, sy;
  logic [ADDR_W-1:0] st_addr, rd_addr, wk_addr, ram_addr;
  logic [47:0] ram_wdata, ram_rdata;
  logic ram_we, ram_re;
  logic [16:0] sum_x, sum_y, sum_m;
  logic [15:0] new_x, new_y, new_m;

  assign mw_ext = {2'b00, map_width};
  assign mh_ext = {2'b00, map_height};
  assign eff_w = (mw_ext == 11'd0) ? 11'd1 : ((mw_ext > COLS_L) ? COLS_L : mw_ext);
  assign eff_h = (mh_ext == 11'd0) ? 11'd1 : ((mh_ext > ROWS_L) ? ROWS_L : mh_ext);

  // Footprint tile; it may fall off the left or top map edge, so coordinates carry a sign.
  assign sx = {3'b000, t_x} + {{8{dx[2]}}, dx};
  assign sy = {3'b000, t_y} + {{8{dy[2]}}, dy};
  assign st_addr = ADDR_W'(sy[9:0] * MAX_COLS + sx[9:0]);
  assign rd_addr = ADDR_W'(t_y * MAX_COLS + t_x);
  assign wk_addr = ADDR_W'(wy * MAX_COLS + wx);

  assign status.clr_last = (clr_addr == LAST_ADDR);
  assign status.st_inmap = !sx[10] && !sy[10] && (sx < eff_w) && (sy < eff_h);
  assign status.st_last  = (dx == HLO) && (dy == HLO);
  assign status.rd_inmap = ({3'b000, t_x} < eff_w) && ({3'b000, t_y} < eff_h);
  assign status.wk_last  = ({1'b0, wx} == eff_w - 11'd1) && ({1'b0, wy} == eff_h - 11'd1);

  always_comb begin
    sum_x = {ram_rdata[47], ram_rdata[47:32]} + {{9{v_x[7]}}, v_x};
    sum_y = {ram_rdata[31], ram_rdata[31:16]} + {{9{v_y[7]}}, v_y};
    sum_m = {1'b0, ram_rdata[15:0]} + FLOW_STEP;
    if (sum_x[16] != sum_x[15]) begin
      new_x = sum_x[16] ? 16'h8000 : 16'h7FFF;
    end else begin
      new_x = sum_x[15:0];
    end
    if (sum_y[16] != sum_y[15]) begin
      new_y = sum_y[16] ? 16'h8000 : 16'h7FFF;
    end else begin
      new_y = sum_y[15:0];
    end
    new_m = sum_m[16] ? 16'hFFFF : sum_m[15:0];
  end

  always_comb begin
    ram_we    = cmd.clr_wr || cmd.st_wr;
    ram_re    = cmd.st_rd || cmd.rd_rd || cmd.ck_rd;
    ram_wdata = cmd.clr_wr ? 48'd0 : {new_x, new_y, new_m};
    if (cmd.clr_wr) begin
      ram_addr = clr_addr;
    end else if (cmd.rd_rd) begin
      ram_addr = rd_addr;
    end else if (cmd.ck_rd) begin
      ram_addr = wk_addr;
    end else begin
      ram_addr = st_addr;
    end
  end

  gsfa_ram #(
    .WIDTH(48),
    .DEPTH(CELLS)
  ) u_grid (
    .clk  (clk),
    .we   (ram_we),
    .re   (ram_re),
    .addr (ram_addr),
    .wdata(ram_wdata),
    .rdata(ram_rdata)
  );

  assign factor_next = (factor << 1) + factor + 32'd1;

  always_comb begin
    case (cmd.mul_sel)
      MUL_X:   mul_src = ram_rdata[47:32];
      MUL_Y:   mul_src = ram_rdata[31:16];
      default: mul_src = ram_rdata[15:0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      map_width  <= MAP_DIM_RESET;
      map_height <= MAP_DIM_RESET;
      clr_addr   <= '0;
      dx <= NEG_HLO;
      dy <= NEG_HLO;
      wx <= '0;
      wy <= '0;
    end else begin
      if (cfg_valid) begin
        if (cfg_index == REG_MAP_WIDTH) begin
          map_width <= cfg_data;
        end else if (cfg_index == REG_MAP_HEIGHT) begin
          map_height <= cfg_data;
        end
      end
      if (cmd.latch) begin
        clr_addr <= '0;
        dx <= NEG_HLO;
        dy <= NEG_HLO;
        wx <= '0;
        wy <= '0;
      end else begin
        if (cmd.clr_wr) begin
          clr_addr <= clr_addr + 1'b1;
        end
        if (cmd.st_step) begin
          if (dx == HLO) begin
            dx <= NEG_HLO;
            dy <= dy + 3'sd1;
          end else begin
            dx <= dx + 3'sd1;
          end
        end
        if (cmd.wk_rst) begin
          wx <= '0;
          wy <= '0;
        end else if (cmd.wk_step) begin
          if ({1'b0, wx} == eff_w - 11'd1) begin
            wx <= '0;
            wy <= wy + 10'd1;
          end else begin
            wx <= wx + 10'd1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      t_x    <= item.tile_x;
      t_y    <= item.tile_y;
      v_x    <= item.vec_x;
      v_y    <= item.vec_y;
      hash   <= '0;
      factor <= '0;
      res_fx <= '0;
      res_fy <= '0;
      res_m  <= '0;
    end else begin
      if (cmd.rd_cap) begin
        res_fx <= ram_rdata[47:32];
        res_fy <= ram_rdata[31:16];
        res_m  <= ram_rdata[15:0];
      end
      if (cmd.acc) begin
        hash <= hash ^ prod;
      end
      if (cmd.mul) begin
        factor <= factor_next;
      end
    end
    if (cmd.mul) begin
      prod <= 32'(mul_src * factor_next);
    end
    if (cmd.load_out) begin
      result.tile_flow_x <= res_fx;
      result.tile_flow_y <= res_fy;
      result.tile_mass   <= res_m;
      result.grid_hash   <= hash;
    end
  end

endmodule

@@ rtl/gsfa_ctrl.sv @@
// Controller state machine: sequences clear sweeps, stamps, reads and checksum walks.
// Depends on gsfa_pkg.
`timescale 1ns / 1ps

module gsfa_ctrl
  import gsfa_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         item_valid,
  input  gsfa_in_t     item,
  output logic         item_ready,
  output logic         result_valid,
  input  logic         result_ready,
  input  gsfa_status_t status,
  output gsfa_cmd_t    cmd
);

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_ST_RD, S_ST_WR, S_RD_RD, S_RD_CAP,
    S_C1_RD, S_C1_X, S_C1_Y, S_C1_ACC, S_C2_RD, S_C2_M, S_C2_ACC, S_FIN
  } state_t;

  state_t state, state_next;
  logic boot;
  logic accept, out_free;

  assign item_ready = (state == S_IDLE);
  assign accept     = item_valid && item_ready;
  assign out_free   = !result_valid || result_ready;

  always_comb begin
    cmd        = '0;
    cmd.mul_sel = MUL_X;
    state_next = state;
    unique case (state)
      S_CLR: begin
        cmd.clr_wr = 1'b1;
        if (status.clr_last) begin
          state_next = boot ? S_IDLE : S_FIN;
        end
      end
      S_IDLE: begin
        if (accept) begin
          cmd.latch = 1'b1;
          unique case (item.operation)
            OP_CLEAR: state_next = S_CLR;
            OP_STAMP: state_next = (item.ground_unit && item.friendly) ? S_ST_RD : S_FIN;
            OP_READ:  state_next = S_RD_RD;
            default:  state_next = S_C1_RD;
          endcase
        end
      end
      S_ST_RD: begin
        if (status.st_inmap) begin
          cmd.st_rd  = 1'b1;
          state_next = S_ST_WR;
        end else if (status.st_last) begin
          state_next = S_FIN;
        end else begin
          cmd.st_step = 1'b1;
        end
      end
      S_ST_WR: begin
        cmd.st_wr = 1'b1;
        if (status.st_last) begin
          state_next = S_FIN;
        end else begin
          cmd.st_step = 1'b1;
          state_next  = S_ST_RD;
        end
      end
      S_RD_RD: begin
        if (status.rd_inmap) begin
          cmd.rd_rd  = 1'b1;
          state_next = S_RD_CAP;
        end else begin
          state_next = S_FIN;
        end
      end
      S_RD_CAP: begin
        cmd.rd_cap = 1'b1;
        state_next = S_FIN;
      end
      S_C1_RD: begin
        cmd.ck_rd  = 1'b1;
        state_next = S_C1_X;
      end
      S_C1_X: begin
        cmd.mul    = 1'b1;
        state_next = S_C1_Y;
      end
      S_C1_Y: begin
        cmd.acc     = 1'b1;
        cmd.mul     = 1'b1;
        cmd.mul_sel = MUL_Y;
        state_next  = S_C1_ACC;
      end
      S_C1_ACC: begin
        cmd.acc = 1'b1;
        if (status.wk_last) begin
          cmd.wk_rst = 1'b1;
          state_next = S_C2_RD;
        end else begin
          cmd.wk_step = 1'b1;
          state_next  = S_C1_RD;
        end
      end
      S_C2_RD: begin
        cmd.ck_rd  = 1'b1;
        state_next = S_C2_M;
      end
      S_C2_M: begin
        cmd.mul     = 1'b1;
        cmd.mul_sel = MUL_M;
        state_next  = S_C2_ACC;
      end
      S_C2_ACC: begin
        cmd.acc = 1'b1;
        if (status.wk_last) begin
          state_next = S_FIN;
        end else begin
          cmd.wk_step = 1'b1;
          state_next  = S_C2_RD;
        end
      end
      S_FIN: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLR;
      boot         <= 1'b1;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_CLR && status.clr_last) begin
        boot <= 1'b0;
      end
      if (cmd.load_out) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!result_valid || result_ready))
    else $error("result word overwritten while still pending");

  a_boot_blocks: assert property (@(posedge clk) disable iff (rst)
    boot |-> !item_ready)
    else $error("input accepted during the reset clearing pass");

  a_wr_after_rd: assert property (@(posedge clk) disable iff (rst)
    cmd.st_wr |-> $past(cmd.st_rd))
    else $error("stamp write without a preceding read");

  a_one_writer: assert property (@(posedge clk) disable iff (rst)
    !(cmd.clr_wr && cmd.st_wr))
    else $error("clear and stamp write at once");

endmodule

@@ rtl/grid_splat_flow_accumulator.sv @@
// Top level of the grid splat flow accumulator.
// Depends on gsfa_pkg, gsfa_ctrl and gsfa_datapath.
`timescale 1ns / 1ps

// Usage:
// Input words (item) carry an operation: clear, stamp, read tile or checksum.
// Every accepted word yields exactly one result word on the result channel.
// The configuration channel writes map_width (index 0) and map_height (index 1);
// it is always ready and should only be written while the block is idle.
// One word is processed at a time; the single grid RAM port sets the pace.
// Steps per word, from acceptance to the result register:
//   clear:    all MAX_COLS * MAX_ROWS cells zeroed, one tile written per cycle
//   stamp:    a read and a write per in-map footprint tile, a step per skipped tile
//             (a unit that does not contribute walks no tiles)
//   read:     registered RAM read, then capture, for an in-map tile; no read off the map
//   checksum: a flow pass (read, x multiply, y multiply, accumulate per tile), then a
//             mass pass (read, mass multiply, accumulate per tile), one multiplier
// After reset the grid is zeroed by a pass over all MAX_COLS * MAX_ROWS cells,
// during which no input word is accepted.
// The result sits in an output register; the next word is accepted while it
// waits, but that word's result holds until the receiver takes the earlier one.

module grid_splat_flow_accumulator
  import gsfa_pkg::*;
#(
  parameter int MAX_COLS = DEF_MAX_COLS,
  parameter int MAX_ROWS = DEF_MAX_ROWS,
  parameter int HALO     = DEF_HALO
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  output logic                 item_ready,
  input  gsfa_in_t             item,
  output logic                 result_valid,
  input  logic                 result_ready,
  output gsfa_out_t            result,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [MAP_DIM_W-1:0] cfg_data
);

  gsfa_cmd_t    cmd;
  gsfa_status_t status;

  assign cfg_ready = 1'b1;

  gsfa_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item        (item),
    .item_ready  (item_ready),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .status      (status),
    .cmd         (cmd)
  );

  gsfa_datapath #(
    .MAX_COLS(MAX_COLS),
    .MAX_ROWS(MAX_ROWS),
    .HALO    (HALO)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .item     (item),
    .cfg_valid(cfg_valid),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .cmd      (cmd),
    .status   (status),
    .result   (result)
  );

endmodule
